// ===== hdl/rada_pkg.sv =====
// Shared constants and control types for the range add difference array.
`default_nettype none
package rada_pkg;

    // Store geometry
    localparam int MAX_LENGTH = 64;
    localparam int ADDR_W     = $clog2(MAX_LENGTH);
    localparam int DATA_W     = 32;

    // Field widths fixed by the interface
    localparam int IDX_W  = 6;
    localparam int AMT_W  = 16;
    localparam int LEN_W  = 7;
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    // Register map (word index)
    localparam logic REG_ARRAY_LENGTH = 1'b0;
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(64);
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_LENGTH);

    // Read address sources
    typedef enum logic [1:0] {
        RD_PORT_LEFT,
        RD_RIGHT_NEXT,
        RD_INDEX_NEXT,
        RD_ZERO
    } rd_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    load_item;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        logic    wr_right;
        logic    sweep_start;
        logic    acc_load;
        logic    idx_inc;
        logic    clear_valid;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_finish;
        logic range_ok;
        logic need_right;
        logic last;
    } dp_stat_t;

endpackage
`default_nettype wire

// ===== hdl/rada_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rada_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== hdl/rada_dp.sv =====
// Datapath: difference store, entry valid flags, item latch, sweep index and running sum.
`default_nettype none
module rada_dp (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire rada_pkg::dp_cmd_t             cmd,
    output rada_pkg::dp_stat_t                 stat,
    input  wire logic [rada_pkg::LEN_W-1:0]    active_len,
    input  wire logic                          s_opcode,
    input  wire logic [rada_pkg::IDX_W-1:0]    s_range_left,
    input  wire logic [rada_pkg::IDX_W-1:0]    s_range_right,
    input  wire logic signed [rada_pkg::AMT_W-1:0] s_add_amount,
    output logic      [rada_pkg::IDX_W-1:0]    m_position,
    output logic signed [rada_pkg::DATA_W-1:0] m_element_sum,
    output logic                               m_last_element
);

    logic [rada_pkg::IDX_W-1:0]  left_reg;
    logic [rada_pkg::IDX_W-1:0]  right_reg;
    logic [rada_pkg::AMT_W-1:0]  amount_reg;
    logic [rada_pkg::ADDR_W-1:0] idx_reg;
    logic [rada_pkg::DATA_W-1:0] acc_reg;
    logic [rada_pkg::DATA_W-1:0] acc_next;
    logic [rada_pkg::MAX_LENGTH-1:0] valid_reg;
    logic                        rd_valid_reg;

    logic [rada_pkg::ADDR_W-1:0] raddr;
    logic [rada_pkg::ADDR_W-1:0] waddr;
    logic [rada_pkg::DATA_W-1:0] wdata;
    logic [rada_pkg::DATA_W-1:0] rdata;
    logic [rada_pkg::DATA_W-1:0] rd_eff;
    logic [rada_pkg::DATA_W-1:0] amount_ext;
    logic [rada_pkg::LEN_W-1:0]  right_plus;
    logic [rada_pkg::LEN_W-1:0]  idx_plus;

    // Status for the controller
    assign right_plus = rada_pkg::LEN_W'(right_reg) + rada_pkg::LEN_W'(1);
    assign idx_plus   = rada_pkg::LEN_W'(idx_reg) + rada_pkg::LEN_W'(1);

    always_comb begin
        stat.is_finish  = s_opcode;
        stat.range_ok   = (s_range_left <= s_range_right) &&
                          (rada_pkg::LEN_W'(s_range_right) < active_len);
        stat.need_right = right_plus < active_len;
        stat.last       = idx_plus == active_len;
    end

    // Read address select
    always_comb begin
        case (cmd.rd_sel)
            rada_pkg::RD_PORT_LEFT:  raddr = rada_pkg::ADDR_W'(s_range_left);
            rada_pkg::RD_RIGHT_NEXT: raddr = rada_pkg::ADDR_W'(right_plus);
            rada_pkg::RD_INDEX_NEXT: raddr = rada_pkg::ADDR_W'(idx_plus);
            rada_pkg::RD_ZERO:       raddr = '0;
            default:                 raddr = '0;
        endcase
    end

    // Read-modify-write: add at left, subtract at right plus one
    assign amount_ext = {{(rada_pkg::DATA_W-rada_pkg::AMT_W){amount_reg[rada_pkg::AMT_W-1]}},
                         amount_reg};
    assign rd_eff     = rd_valid_reg ? rdata : '0;
    assign waddr      = cmd.wr_right ? rada_pkg::ADDR_W'(right_plus)
                                     : rada_pkg::ADDR_W'(left_reg);
    assign wdata      = cmd.wr_right ? (rd_eff - amount_ext) : (rd_eff + amount_ext);
    assign acc_next   = acc_reg + rd_eff;

    rada_ram #(
        .WIDTH(rada_pkg::DATA_W),
        .DEPTH(rada_pkg::MAX_LENGTH)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.wr_en),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Entry valid flags: unwritten entries read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (cmd.clear_valid) begin
                valid_reg <= '0;
            end else if (cmd.wr_en) begin
                valid_reg[waddr] <= 1'b1;
            end
            if (cmd.rd_en) begin
                rd_valid_reg <= valid_reg[raddr];
            end
        end
    end

    // Item latch
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            left_reg   <= s_range_left;
            right_reg  <= s_range_right;
            amount_reg <= s_add_amount;
        end
    end

    // Sweep index and running prefix sum
    always_ff @(posedge aclk) begin
        if (cmd.sweep_start) begin
            idx_reg <= '0;
            acc_reg <= '0;
        end else begin
            if (cmd.acc_load) begin
                acc_reg <= acc_next;
            end
            if (cmd.idx_inc) begin
                idx_reg <= idx_reg + rada_pkg::ADDR_W'(1);
            end
        end
    end

    assign m_position     = rada_pkg::IDX_W'(idx_reg);
    assign m_element_sum  = acc_reg;
    assign m_last_element = stat.last;

endmodule
`default_nettype wire

// ===== hdl/rada_ctrl.sv =====
// Controller: sequences update read-modify-writes and the finish sweep.
`default_nettype none
module rada_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    input  wire rada_pkg::dp_stat_t stat,
    output rada_pkg::dp_cmd_t       cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_UPD_L = 5'b00010,
        ST_UPD_R = 5'b00100,
        ST_FETCH = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_EMIT);

    // Next state and commands
    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.rd_sel  = rada_pkg::RD_ZERO;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    if (stat.is_finish) begin
                        cmd.rd_en       = 1'b1;
                        cmd.rd_sel      = rada_pkg::RD_ZERO;
                        cmd.sweep_start = 1'b1;
                        state_next      = ST_FETCH;
                    end else if (stat.range_ok) begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = rada_pkg::RD_PORT_LEFT;
                        state_next = ST_UPD_L;
                    end
                end
            end
            ST_UPD_L: begin
                cmd.wr_en = 1'b1;
                if (stat.need_right) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = rada_pkg::RD_RIGHT_NEXT;
                    state_next = ST_UPD_R;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_UPD_R: begin
                cmd.wr_en    = 1'b1;
                cmd.wr_right = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_FETCH: begin
                cmd.acc_load = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT: begin
                if (m_ready) begin
                    if (stat.last) begin
                        cmd.clear_valid = 1'b1;
                        state_next      = ST_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        cmd.rd_en   = 1'b1;
                        cmd.rd_sel  = rada_pkg::RD_INDEX_NEXT;
                        state_next  = ST_FETCH;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // The second write of an update always ends the item
    a_upd_r_done: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_UPD_R |=> state_reg == ST_IDLE)
        else $error("update did not finish after second write");

    // A fetched element is always presented next cycle
    a_fetch_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FETCH |=> state_reg == ST_EMIT)
        else $error("fetched element not presented");

    // The store is never written while a sweep is in progress
    a_no_write_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FETCH || state_reg == ST_EMIT) |-> !cmd.wr_en)
        else $error("store written during sweep");

    // Store flags are cleared only when the last element leaves
    a_clear_last: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear_valid |-> (m_valid && m_ready && stat.last))
        else $error("store cleared outside final element");

endmodule
`default_nettype wire

// ===== hdl/range_add_difference_array.sv =====
// Update: accept reads the entry at left; ST_UPD_L writes it and reads the entry at right plus one,
// written in ST_UPD_R unless the range ends at the last position; out-of-range updates drop on accept.
// Finish: each element is fetched in ST_FETCH and shown in ST_EMIT, held until m_ready; the next
// element is read only once the current one is taken; the store has a single registered read port.
// Reset: store entries read as zero through per-entry valid flags cleared at once,
// array_length returns to 64; no clearing pass, the block accepts items right after reset.
`default_nettype none
module range_add_difference_array (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [rada_pkg::APB_AW-1:0]       paddr,
    input  wire logic [rada_pkg::APB_DW-1:0]       pwdata,
    output logic      [rada_pkg::APB_DW-1:0]       prdata,
    output logic                                   pready,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_opcode,
    input  wire logic [rada_pkg::IDX_W-1:0]        s_range_left,
    input  wire logic [rada_pkg::IDX_W-1:0]        s_range_right,
    input  wire logic signed [rada_pkg::AMT_W-1:0] s_add_amount,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic      [rada_pkg::IDX_W-1:0]        m_position,
    output logic signed [rada_pkg::DATA_W-1:0]     m_element_sum,
    output logic                                   m_last_element
);

    logic [rada_pkg::LEN_W-1:0] len_reg;
    logic [rada_pkg::LEN_W-1:0] active_len;
    logic                       reg_sel;
    rada_pkg::dp_cmd_t          cmd;
    rada_pkg::dp_stat_t         stat;

    // Configuration register
    assign pready  = 1'b1;
    assign reg_sel = (paddr[rada_pkg::APB_AW-1] == rada_pkg::REG_ARRAY_LENGTH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= rada_pkg::LEN_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            len_reg <= pwdata[rada_pkg::LEN_W-1:0];
        end
    end

    assign prdata = reg_sel ? {{(rada_pkg::APB_DW-rada_pkg::LEN_W){1'b0}}, len_reg} : '0;

    // Zero length counts as one, oversize clamps to the store depth
    always_comb begin
        if (len_reg == '0) begin
            active_len = rada_pkg::LEN_W'(1);
        end else if (len_reg > rada_pkg::LEN_MAX) begin
            active_len = rada_pkg::LEN_MAX;
        end else begin
            active_len = len_reg;
        end
    end

    rada_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    rada_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .active_len     (active_len),
        .s_opcode       (s_opcode),
        .s_range_left   (s_range_left),
        .s_range_right  (s_range_right),
        .s_add_amount   (s_add_amount),
        .m_position     (m_position),
        .m_element_sum  (m_element_sum),
        .m_last_element (m_last_element)
    );

endmodule
`default_nettype wire
